// ===== src/xdpc_pkg.sv =====
// Shared types and constants for the repeating-key XOR decryptor with a plaintext check.
// Used by xor_decrypt_plaintext_check; depends on nothing else.
package xdpc_pkg;

  localparam int unsigned MAX_LEN   = 4096;
  localparam int unsigned KEY_BYTES = 8;

  localparam int unsigned CNT_W     = $clog2(MAX_LEN + 1);
  localparam int unsigned PROD_W    = CNT_W + 5;
  localparam int unsigned KEY_POS_W = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
  localparam int unsigned KEY_W     = 8 * KEY_BYTES;
  localparam int unsigned KLEN_W    = 4;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_W     = 64;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_VALUE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH = 1'd1;

  localparam logic [KLEN_W-1:0] KEY_LEN_RESET = 4'd6;

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_LEN);

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_E     = 8'h65;
  localparam logic [7:0] CH_G     = 8'h67;
  localparam logic [7:0] CH_H     = 8'h68;
  localparam logic [7:0] CH_M     = 8'h6d;
  localparam logic [7:0] CH_N     = 8'h6e;
  localparam logic [7:0] CH_O     = 8'h6f;
  localparam logic [7:0] CH_Y     = 8'h79;
  localparam logic [7:0] CH_Z     = 8'h7a;
  localparam logic [7:0] CASE_GAP = 8'h20;

  // word flag bit positions
  localparam int unsigned W_HOGY = 0;
  localparam int unsigned W_NEM  = 1;
  localparam int unsigned W_AZ   = 2;
  localparam int unsigned W_HA   = 3;

  typedef struct packed {
    logic [7:0] cipher_byte;
    logic       last_byte;
  } xdpc_in_t;

  typedef struct packed {
    logic [7:0] plain_byte;
    logic       verdict_valid;
    logic       plausible;
  } xdpc_out_t;

endpackage

// ===== src/xor_decrypt_plaintext_check.sv =====
// Top level: repeating-key XOR decryptor with per-message plaintext plausibility check.
// Depends on xdpc_pkg for payload types, constants and register indexes.
//
// Usage:
//   Input channel (in_valid/in_ready/in_data) carries one ciphertext word per
//   handshake: a byte plus a flag marking the last byte of the message.
//   Result channel (out_valid/out_ready/out_data) returns exactly one word per
//   input word: the plaintext byte, and on the last byte the verdict.
//   Configuration port: cfg_wr_en with cfg_index and cfg_data, written at any
//   edge with cfg_wr_en high; index REG_KEY_VALUE loads the 64-bit key (byte 0
//   in the low bits), REG_KEY_LENGTH the 4-bit key length. Write only while idle.
// Output: the result word is in the output register in the cycle after the
//   input word is accepted.
// Throughput: one word per cycle unless stalled; all decode, counting and
//   matching sits in one combinational stage in front of the output register.
// Stall: in_ready is high while the output register is empty or being drained
//   this cycle, so a stalled receiver holds the result and stops intake after
//   exactly one word.
// Reset (rst_n low, synchronous): empty the output register, clear the
//   message state, key value to zero, key length to 6.
// End of message: after the last byte, clear the counters, word flags, byte
//   history, zero marker and key position; keep the configuration.
module xor_decrypt_plaintext_check (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  xdpc_pkg::xdpc_in_t               in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output xdpc_pkg::xdpc_out_t              out_data,
  input  logic                             cfg_wr_en,
  input  logic [xdpc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [xdpc_pkg::CFG_W-1:0]       cfg_data
);

  // configuration
  logic [xdpc_pkg::KEY_W-1:0]     key_value_r;
  logic [xdpc_pkg::KLEN_W-1:0]    key_len_r;

  // message state
  logic [xdpc_pkg::KEY_POS_W-1:0] key_pos_r,   key_pos_nxt;
  logic [xdpc_pkg::CNT_W-1:0]     byte_cnt_r,  byte_cnt_nxt;
  logic [xdpc_pkg::CNT_W-1:0]     space_cnt_r, space_cnt_nxt;
  logic [3:0]                     flags_r,     flags_nxt;
  logic [7:0]                     hist0_r,     hist0_nxt;
  logic [7:0]                     hist1_r,     hist1_nxt;
  logic [7:0]                     hist2_r,     hist2_nxt;
  logic                           zero_seen_r, zero_seen_nxt;

  // output register
  logic                           out_valid_r;
  xdpc_pkg::xdpc_out_t            out_data_r,  out_data_nxt;

  logic                           in_fire;
  logic [xdpc_pkg::KLEN_W-1:0]    eff_len;
  logic [xdpc_pkg::KEY_POS_W-1:0] pos;
  logic [xdpc_pkg::KLEN_W-1:0]    pos_inc;
  logic [7:0]                     key_byte;
  logic [7:0]                     plain;
  logic [7:0]                     lower;
  logic [xdpc_pkg::PROD_W-1:0]    space_x20;
  logic                           verdict;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Decrypt, count, match and judge one byte.
  always_comb begin
    // clamp key length into 1..KEY_BYTES
    if (key_len_r == '0) begin
      eff_len = xdpc_pkg::KLEN_W'(1);
    end else if (key_len_r > xdpc_pkg::KLEN_W'(xdpc_pkg::KEY_BYTES)) begin
      eff_len = xdpc_pkg::KLEN_W'(xdpc_pkg::KEY_BYTES);
    end else begin
      eff_len = key_len_r;
    end

    // position past a lowered length restarts at key byte 0
    pos      = (xdpc_pkg::KLEN_W'(key_pos_r) < eff_len) ? key_pos_r : '0;
    pos_inc  = xdpc_pkg::KLEN_W'(pos) + xdpc_pkg::KLEN_W'(1);
    key_byte = key_value_r[8*pos +: 8];
    plain    = in_data.cipher_byte ^ key_byte;

    key_pos_nxt = (pos_inc >= eff_len) ? '0 : pos_inc[xdpc_pkg::KEY_POS_W-1:0];

    byte_cnt_nxt  = (byte_cnt_r < xdpc_pkg::CNT_MAX) ? byte_cnt_r + 1'b1 : byte_cnt_r;
    space_cnt_nxt = space_cnt_r;
    if (plain == xdpc_pkg::CH_SPACE && space_cnt_r < xdpc_pkg::CNT_MAX) begin
      space_cnt_nxt = space_cnt_r + 1'b1;
    end

    lower = plain;
    if (plain inside {[8'h41:8'h5a]}) begin
      lower = plain + xdpc_pkg::CASE_GAP;
    end

    // a zero byte stops word matching for the rest of the message
    zero_seen_nxt = zero_seen_r || (plain == 8'h00);
    flags_nxt     = flags_r;
    hist0_nxt     = hist0_r;
    hist1_nxt     = hist1_r;
    hist2_nxt     = hist2_r;
    if (!zero_seen_nxt) begin
      if (hist2_r == xdpc_pkg::CH_H && hist1_r == xdpc_pkg::CH_O &&
          hist0_r == xdpc_pkg::CH_G && lower == xdpc_pkg::CH_Y) begin
        flags_nxt[xdpc_pkg::W_HOGY] = 1'b1;
      end
      if (hist1_r == xdpc_pkg::CH_N && hist0_r == xdpc_pkg::CH_E &&
          lower == xdpc_pkg::CH_M) begin
        flags_nxt[xdpc_pkg::W_NEM] = 1'b1;
      end
      if (hist0_r == xdpc_pkg::CH_A && lower == xdpc_pkg::CH_Z) begin
        flags_nxt[xdpc_pkg::W_AZ] = 1'b1;
      end
      if (hist0_r == xdpc_pkg::CH_H && lower == xdpc_pkg::CH_A) begin
        flags_nxt[xdpc_pkg::W_HA] = 1'b1;
      end
      hist2_nxt = hist1_r;
      hist1_nxt = hist0_r;
      hist0_nxt = lower;
    end

    // 20 * spaces as two shifted adds
    space_x20 = (xdpc_pkg::PROD_W'(space_cnt_nxt) << 4) +
                (xdpc_pkg::PROD_W'(space_cnt_nxt) << 2);
    verdict   = (byte_cnt_nxt > space_cnt_nxt) &&
                (xdpc_pkg::PROD_W'(byte_cnt_nxt) < space_x20) &&
                (flags_nxt == 4'hf);

    out_data_nxt.plain_byte    = plain;
    out_data_nxt.verdict_valid = in_data.last_byte;
    out_data_nxt.plausible     = in_data.last_byte && verdict;

    // end of message: drop all message state
    if (in_data.last_byte) begin
      key_pos_nxt   = '0;
      byte_cnt_nxt  = '0;
      space_cnt_nxt = '0;
      flags_nxt     = '0;
      hist0_nxt     = '0;
      hist1_nxt     = '0;
      hist2_nxt     = '0;
      zero_seen_nxt = 1'b0;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_value_r <= '0;
      key_len_r   <= xdpc_pkg::KEY_LEN_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        xdpc_pkg::REG_KEY_VALUE:  key_value_r <= cfg_data[xdpc_pkg::KEY_W-1:0];
        xdpc_pkg::REG_KEY_LENGTH: key_len_r   <= cfg_data[xdpc_pkg::KLEN_W-1:0];
        default: ;
      endcase
    end
  end

  // message state: advance on every accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_pos_r   <= '0;
      byte_cnt_r  <= '0;
      space_cnt_r <= '0;
      flags_r     <= '0;
      hist0_r     <= '0;
      hist1_r     <= '0;
      hist2_r     <= '0;
      zero_seen_r <= 1'b0;
    end else if (in_fire) begin
      key_pos_r   <= key_pos_nxt;
      byte_cnt_r  <= byte_cnt_nxt;
      space_cnt_r <= space_cnt_nxt;
      flags_r     <= flags_nxt;
      hist0_r     <= hist0_nxt;
      hist1_r     <= hist1_nxt;
      hist2_r     <= hist2_nxt;
      zero_seen_r <= zero_seen_nxt;
    end
  end

  // output register: load on accept, hold while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  // checks
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_data.last_byte) |=>
      (byte_cnt_r == '0 && space_cnt_r == '0 && flags_r == '0 && !zero_seen_r))
    else $error("message state not cleared after last word");

  a_space_le_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    space_cnt_r <= byte_cnt_r)
    else $error("space count exceeds byte count");

  a_cnt_sat: assert property (@(posedge clk) disable iff (!rst_n)
    byte_cnt_r <= xdpc_pkg::CNT_MAX)
    else $error("byte count above saturation limit");

  a_verdict_tag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.plausible) |-> out_data_r.verdict_valid)
    else $error("plausible set on a non-final word");

  a_no_intake_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !in_ready)
    else $error("intake while result register is stalled");

endmodule
